// ===== hw/rtl/hbps_pkg.sv =====
// Shared types and constants for the slew-limited H-bridge PWM core.
// Holds the word layouts of both channels, the state and configuration records,
// and the configuration register indexes. Depends on nothing else.
package hbps_pkg;

  // Field widths.
  localparam int DutyWidth   = 12;
  localparam int PeriodWidth = 11;
  localparam int StepWidth   = 8;
  localparam int CfgWidth    = (PeriodWidth > StepWidth) ? PeriodWidth : StepWidth;

  // Configuration register indexes and reset values.
  localparam logic CfgPwmPeriod = 1'b0;
  localparam logic CfgRampStep  = 1'b1;
  localparam logic [PeriodWidth-1:0] PeriodReset = PeriodWidth'(1600);
  localparam logic [StepWidth-1:0]   StepReset   = StepWidth'(3);

  // Bit positions of the switch levels.
  localparam int SwOne   = 0;
  localparam int SwTwo   = 1;
  localparam int SwThree = 2;
  localparam int SwFour  = 3;

  // One input word: one PWM timer tick.
  typedef struct packed {
    logic signed [DutyWidth-1:0] target_duty;
    logic                        disable_pin;
    logic                        soft_kill;
    logic                        link_active;
    logic                        bridge_kill;
    logic                        bridge_fuse;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic                        switch_one;
    logic                        switch_two;
    logic                        switch_three;
    logic                        switch_four;
    logic signed [DutyWidth-1:0] applied_duty;
    logic                        bridge_enabled;
  } out_word_t;

  // Configuration registers as seen by the tick logic.
  typedef struct packed {
    logic [PeriodWidth-1:0] pwm_period;
    logic [StepWidth-1:0]   ramp_step;
  } cfg_t;

  // Bridge state carried from tick to tick.
  typedef struct packed {
    logic [PeriodWidth-1:0]      counter;
    logic signed [DutyWidth-1:0] duty;
    logic [3:0]                  switches;
  } core_state_t;

endpackage

// ===== hw/rtl/hbps_tick.sv =====
// Combinational update for one PWM timer tick: counter, ramped duty and switch levels.
// Uses the types and constants of hbps_pkg.
module hbps_tick (
  input  hbps_pkg::cfg_t        cfg,
  input  hbps_pkg::core_state_t state,
  input  hbps_pkg::in_word_t    word,
  output hbps_pkg::core_state_t state_next,
  output hbps_pkg::out_word_t   result
);

  localparam int W  = hbps_pkg::DutyWidth;
  localparam int PW = hbps_pkg::PeriodWidth;
  localparam int SW = hbps_pkg::StepWidth;
  // Width for the ramp sums: duty plus or minus a full step.
  localparam int RW = ((W > SW) ? W : SW) + 2;
  // Width for the counter against duty magnitude compare.
  localparam int CW = ((W > PW) ? W : PW) + 2;

  logic                   en;
  logic [PW-1:0]          cnt_up;
  logic                   restart;
  logic [PW-1:0]          cnt_new;
  logic signed [RW-1:0]   t_ext;
  logic signed [RW-1:0]   d_ext;
  logic signed [RW-1:0]   s_ext;
  logic signed [RW-1:0]   s_m1;
  logic signed [RW-1:0]   ramped;
  logic signed [W-1:0]    duty_new;
  logic signed [CW-1:0]   cnt_cmp;
  logic signed [CW-1:0]   duty_cmp;
  logic [3:0]             sw_new;

  // The bridge runs only with every enable condition met.
  assign en = !word.disable_pin && !word.soft_kill && word.link_active &&
              !word.bridge_kill && !word.bridge_fuse;

  // Counter counts up and saturates at the period; it restarts when enabled at the period.
  assign cnt_up  = (state.counter < cfg.pwm_period) ? state.counter + PW'(1) : cfg.pwm_period;
  assign restart = en && (cnt_up == cfg.pwm_period);
  assign cnt_new = restart ? '0 : cnt_up;

  // Ramp toward the target by at most one step, snapping when close.
  assign t_ext = {{(RW-W){word.target_duty[W-1]}}, word.target_duty};
  assign d_ext = {{(RW-W){state.duty[W-1]}}, state.duty};
  assign s_ext = {{(RW-SW){1'b0}}, cfg.ramp_step};
  assign s_m1  = s_ext - RW'(1);

  always_comb begin
    if (t_ext > d_ext + s_m1) begin
      ramped = d_ext + s_ext;
    end else if (t_ext < d_ext - s_m1) begin
      ramped = d_ext - s_ext;
    end else begin
      ramped = t_ext;
    end
  end

  assign duty_new = restart ? ramped[W-1:0] : state.duty;

  // Compare the counter with the magnitude of the duty.
  assign cnt_cmp  = {{(CW-PW){1'b0}}, cnt_new};
  assign duty_cmp = {{(CW-W){duty_new[W-1]}}, duty_new};

  // Sign-magnitude switch drive; zero duty brakes and a disable clears everything.
  always_comb begin
    sw_new = state.switches;
    if (!en) begin
      sw_new = '0;
    end else if (duty_cmp > 0) begin
      if (cnt_cmp < duty_cmp) begin
        sw_new[hbps_pkg::SwTwo]   = 1'b0;
        sw_new[hbps_pkg::SwThree] = 1'b0;
        sw_new[hbps_pkg::SwOne]   = 1'b1;
        sw_new[hbps_pkg::SwFour]  = 1'b1;
      end else begin
        sw_new[hbps_pkg::SwOne] = 1'b0;
      end
    end else if (duty_cmp < 0) begin
      if (cnt_cmp < -duty_cmp) begin
        sw_new[hbps_pkg::SwOne]   = 1'b0;
        sw_new[hbps_pkg::SwFour]  = 1'b0;
        sw_new[hbps_pkg::SwTwo]   = 1'b1;
        sw_new[hbps_pkg::SwThree] = 1'b1;
      end else begin
        sw_new[hbps_pkg::SwThree] = 1'b0;
      end
    end else begin
      sw_new[hbps_pkg::SwOne]   = 1'b0;
      sw_new[hbps_pkg::SwThree] = 1'b0;
      sw_new[hbps_pkg::SwTwo]   = 1'b1;
      sw_new[hbps_pkg::SwFour]  = 1'b1;
    end
  end

  // Next state and the result word.
  assign state_next.counter  = cnt_new;
  assign state_next.duty     = duty_new;
  assign state_next.switches = sw_new;

  assign result.switch_one     = sw_new[hbps_pkg::SwOne];
  assign result.switch_two     = sw_new[hbps_pkg::SwTwo];
  assign result.switch_three   = sw_new[hbps_pkg::SwThree];
  assign result.switch_four    = sw_new[hbps_pkg::SwFour];
  assign result.applied_duty   = duty_new;
  assign result.bridge_enabled = en;

endmodule

// ===== hw/rtl/hbridge_pwm_slew_limited_core.sv =====
// Top level of the slew-limited sign-magnitude H-bridge PWM core.
// Holds configuration, bridge state and the output register with skid stage;
// uses hbps_pkg and hbps_tick.
//
// Usage:
// Each input word on in_data (in_valid / in_stall) is one PWM timer tick with the
// signed target duty and the enable, kill and fuse lines. Every accepted word gives
// exactly one result word on out_data (out_valid / out_stall) with the four switch
// levels, the applied duty and the enable status.
// Each result is registered in the output register, or in the skid stage while
// the receiver stalls. A word is accepted every cycle while the receiver takes
// results; the tick update is one logic pass from bridge state to output register.
// When the receiver stalls, one further word is taken into the skid stage, after
// which in_stall rises until the output register drains.
// Configuration is written through cfg_we, cfg_index and cfg_data: index 0 is the
// PWM period, index 1 the ramp step. Write only while the core is idle.
// Reset (rst, synchronous) sets the period to 1600 ticks and the step to 3,
// clears the counter and duty, turns all switches off and empties the output side.
module hbridge_pwm_slew_limited_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  hbps_pkg::in_word_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output hbps_pkg::out_word_t              out_data,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [hbps_pkg::CfgWidth-1:0]    cfg_data
);

  hbps_pkg::cfg_t        cfg;
  hbps_pkg::core_state_t state;
  hbps_pkg::core_state_t state_next;
  hbps_pkg::out_word_t   result;
  hbps_pkg::out_word_t   skid;
  logic                  skid_valid;
  logic                  accept;
  logic                  out_free;

  // Handshake: the skid stage being full is the only reason to stall.
  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pwm_period <= hbps_pkg::PeriodReset;
      cfg.ramp_step  <= hbps_pkg::StepReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hbps_pkg::CfgPwmPeriod: cfg.pwm_period <= cfg_data[hbps_pkg::PeriodWidth-1:0];
        hbps_pkg::CfgRampStep:  cfg.ramp_step  <= cfg_data[hbps_pkg::StepWidth-1:0];
        default: ;
      endcase
    end
  end

  // Tick update logic.
  hbps_tick u_tick (
    .cfg        (cfg),
    .state      (state),
    .word       (in_data),
    .state_next (state_next),
    .result     (result)
  );

  // Bridge state advances on every accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.counter  <= '0;
      state.duty     <= '0;
      state.switches <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Output register and skid stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid;
      end else if (accept) begin
        out_data <= result;
      end
    end else if (accept) begin
      skid <= result;
    end
  end

  // A full skid stage always sits behind a full output register.
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid stage full while output register empty");

  // A word taken while the output is held must land in the skid stage.
  assert property (@(posedge clk) disable iff (rst)
    (accept && out_valid && out_stall) |=> skid_valid)
    else $error("word accepted under stall was not kept");

  // Both high side switches are never on together.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.switch_one && out_data.switch_three))
    else $error("both high side switches on");

  // A disabled bridge shows every switch off.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.bridge_enabled) |->
      !(out_data.switch_one || out_data.switch_two ||
        out_data.switch_three || out_data.switch_four))
    else $error("switch on while bridge disabled");

endmodule
